[rtl/sn2d_pkg.sv]
// ----------------------------------------------------------------------------
// sn2d_pkg
// Shared types, constants and lookup functions for the 2d simplex noise block.
// ----------------------------------------------------------------------------
package sn2d_pkg;

    localparam int PERM_SIZE_DEF       = 256;
    localparam int GRADIENT_COUNT_DEF  = 12;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam logic signed [31:0] F2_Q30 = 32'sd393016785;
    localparam logic signed [32:0] G2_Q32 = 33'sd907633386;
    localparam logic signed [47:0] ONE_Q32 = 48'sh1_0000_0000;
    localparam logic signed [63:0] HALF_Q48 = 64'sh0000_8000_0000_0000;
    localparam logic signed [7:0]  NOISE_SCALE = 8'sd70;

    localparam logic CFG_RANGE_MIN = 1'b0;
    localparam logic CFG_RANGE_MAX = 1'b1;

    typedef logic signed [15:0] sample_t;

    function automatic logic [7:0] perm_lookup(input logic [7:0] k);
        logic [7:0] tbl [0:255];
        tbl = '{
        151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,
        8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,
        35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,
        134,139,48,27,166,77,146,158,231,83,111,229,122,60,211,133,230,220,105,92,41,
        55,46,245,40,244,102,143,54,65,25,63,161,1,216,80,73,209,76,132,187,208,89,
        18,169,200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,52,217,226,
        250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,59,227,47,16,58,17,182,
        189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,101,155,167,43,
        172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,
        228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,
        107,49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,
        138,236,205,93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180};
        return tbl[k];
    endfunction

    // gradient x/y components, -1/0/+1, as 2-bit signed
    function automatic logic signed [1:0] grad_x(input logic [3:0] g);
        logic signed [1:0] r;
        case (g)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd12: r = 2'sd1;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd13: r = -2'sd1;
            default:                       r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] grad_y(input logic [3:0] g);
        logic signed [1:0] r;
        case (g)
            4'd0, 4'd1, 4'd8, 4'd10, 4'd12, 4'd13: r = 2'sd1;
            4'd2, 4'd3, 4'd9, 4'd11, 4'd14, 4'd15: r = -2'sd1;
            default:                               r = 2'sd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/sn2d_corner.sv]
// ----------------------------------------------------------------------------
// sn2d_corner
// Pipelined contribution of one simplex corner: (0.5 - d^2)^4 * dot(grad, d).
// ----------------------------------------------------------------------------
module sn2d_corner
(
    input  logic               clk,
    input  logic signed [35:0] dx32,
    input  logic signed [35:0] dy32,
    input  logic [3:0]         grad_sel,
    output logic signed [63:0] contrib
);
    import sn2d_pkg::*;

    // stage a: Q24 offsets
    logic signed [27:0] dx_a_reg, dy_a_reg;
    logic [3:0]         g_a_reg;
    // stage b: squares
    logic signed [55:0] sqx_b_reg, sqy_b_reg;
    logic signed [27:0] dx_b_reg, dy_b_reg;
    logic [3:0]         g_b_reg;
    // stage c: t in Q30 and dot
    logic [31:0]        t_c_reg;
    logic signed [29:0] dot_c_reg;
    // stage d: t^2
    logic [63:0]        t2w_d_reg;
    logic signed [29:0] dot_d_reg;
    // stage e: t^4
    logic [63:0]        t4w_e_reg;
    logic signed [29:0] dot_e_reg;

    logic signed [63:0] t_c_next;
    logic signed [29:0] dot_c_next;
    logic [31:0]        t2_d, t4_e;

    always_comb
    begin
        t_c_next = HALF_Q48 - 64'(sqx_b_reg) - 64'(sqy_b_reg);
        dot_c_next = 30'(30'(grad_x(g_b_reg)) * 30'(dx_b_reg))
                   + 30'(30'(grad_y(g_b_reg)) * 30'(dy_b_reg));
        t2_d = t2w_d_reg[61:30];
        t4_e = t4w_e_reg[61:30];
    end

    always_ff @(posedge clk)
    begin
        dx_a_reg  <= dx32[35:8];
        dy_a_reg  <= dy32[35:8];
        g_a_reg   <= grad_sel;
        sqx_b_reg <= dx_a_reg * dx_a_reg;
        sqy_b_reg <= dy_a_reg * dy_a_reg;
        dx_b_reg  <= dx_a_reg;
        dy_b_reg  <= dy_a_reg;
        g_b_reg   <= g_a_reg;
        t_c_reg   <= t_c_next[63] ? 32'd0 : 32'(t_c_next >>> 18);
        dot_c_reg <= dot_c_next;
        t2w_d_reg <= 64'(t_c_reg) * 64'(t_c_reg);
        dot_d_reg <= dot_c_reg;
        t4w_e_reg <= 64'(t2_d) * 64'(t2_d);
        dot_e_reg <= dot_d_reg;
        contrib   <= $signed({1'b0, t4_e}) * dot_e_reg;
    end
endmodule

[rtl/simplex_noise_2d.sv]
// ----------------------------------------------------------------------------
// simplex_noise_2d
// 2d simplex noise on a Q16.16 point, raw Q1.15 and range-scaled outputs.
// ----------------------------------------------------------------------------
// usage:
//   pulse start with coord_x/coord_y; busy is always low, so one beat can be
//   taken every cycle. each beat yields one result: done is high for one
//   cycle with noise_raw and noise_scaled.
//   throughput is one point per cycle, set by the fully pipelined corner
//   units and the multiplier chain t -> t^2 -> t^4 -> t^4*dot.
//   range_min/range_max are written through cfg_we/cfg_index/cfg_data while
//   the pipe is empty; an index beyond the list is ignored.
//   reset clears the valid chain and loads the default range; results in
//   flight are dropped. the receiver cannot stall, so done is never held.
// ----------------------------------------------------------------------------
module simplex_noise_2d
#(
    parameter int PERM_SIZE       = sn2d_pkg::PERM_SIZE_DEF,
    parameter int GRADIENT_COUNT  = sn2d_pkg::GRADIENT_COUNT_DEF,
    parameter int COORD_FRAC_BITS = sn2d_pkg::COORD_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                done,
    output logic signed [15:0]  noise_raw,
    output logic signed [15:0]  noise_scaled
);
    import sn2d_pkg::*;

    localparam int PW = $clog2(PERM_SIZE) + 1;
    localparam int NV = 13;
    localparam int GREC = (65536 + GRADIENT_COUNT - 1) / GRADIENT_COUNT;

    logic [NV-1:0] vld_reg;
    logic signed [15:0] rmin_reg, rmax_reg;

    // stage 1: X, Y (Q32), skew
    logic signed [63:0] xq_1_reg, yq_1_reg;
    logic signed [63:0] skw_1_reg;
    // stage 2: cell indices
    logic signed [63:0] xq_2_reg, yq_2_reg;
    logic signed [31:0] i_2_reg, j_2_reg;
    // stage 3: offsets x0,y0
    logic signed [35:0] x0_3_reg, y0_3_reg;
    logic [PW-2:0]      ii_3_reg, jj_3_reg;
    // stage 4: all three offsets, first hashing level
    logic signed [35:0] x0_4_reg, y0_4_reg, x1_4_reg, y1_4_reg, x2_4_reg, y2_4_reg;
    logic [PW-2:0]      ii_4_reg;
    logic               i1_4_reg;
    logic [7:0]         pj0_4_reg, pj1_4_reg, pj2_4_reg;
    // stage 5: gradient selectors
    logic signed [35:0] x0_5_reg, y0_5_reg, x1_5_reg, y1_5_reg, x2_5_reg, y2_5_reg;
    logic [3:0]         g0_5_reg, g1_5_reg, g2_5_reg;
    // corner outputs are valid at stage 11 (6 regs inside)
    logic signed [63:0] c0, c1, c2;
    logic signed [15:0] n_12_reg;
    logic signed [33:0] v_13_reg;

    function automatic logic [PW-2:0] pmod(input logic signed [33:0] k);
        logic signed [33:0] r;
        r = k % 34'(PERM_SIZE);
        if (r < 0)
            r = r + 34'(PERM_SIZE);
        return r[PW-2:0];
    endfunction

    function automatic logic [7:0] pat(input logic [PW:0] k);
        logic [PW:0] r;
        r = (k >= (PW+1)'(PERM_SIZE)) ? k - (PW+1)'(PERM_SIZE) : k;
        r = (r >= (PW+1)'(PERM_SIZE)) ? r - (PW+1)'(PERM_SIZE) : r;
        return perm_lookup(8'(r));
    endfunction

    // h mod GRADIENT_COUNT by reciprocal multiply, exact for any 8-bit h
    function automatic logic [3:0] gsel(input logic [7:0] h);
        logic [24:0] prod;
        logic [7:0]  quo;
        logic [7:0]  rem;
        prod = 25'(h) * 25'(GREC);
        quo  = prod[23:16];
        rem  = h - 8'(12'(quo) * 12'(GRADIENT_COUNT));
        return rem[3:0];
    endfunction

    logic signed [63:0] sum_x;
    logic signed [63:0] i_2_next, j_2_next;
    logic signed [63:0] t_3;
    logic signed [63:0] x0_3_next, y0_3_next;
    logic signed [63:0] n_w;
    logic signed [15:0] n_12_next;
    logic signed [33:0] v_13_next;
    logic signed [17:0] sc_w;

    assign busy = 1'b0;

    always_comb
    begin
        sum_x    = (64'(coord_x) + 64'(coord_y)) * 64'(F2_Q30);
        i_2_next = (64'(xq_1_reg) + (skw_1_reg >>> (COORD_FRAC_BITS - 2))) >>> 32;
        j_2_next = (64'(yq_1_reg) + (skw_1_reg >>> (COORD_FRAC_BITS - 2))) >>> 32;
        t_3      = (64'(i_2_reg) + 64'(j_2_reg)) * 64'(G2_Q32);
        x0_3_next = 64'(xq_2_reg) - (64'(i_2_reg) <<< 32) + t_3;
        y0_3_next = 64'(yq_2_reg) - (64'(j_2_reg) <<< 32) + t_3;
        n_w = ((c0 + c1 + c2) * 64'sd70 + (64'sd1 <<< 38)) >>> 39;
        if (n_w > 64'sd32767)
            n_12_next = 16'sh7fff;
        else if (n_w < -64'sd32768)
            n_12_next = 16'sh8000;
        else
            n_12_next = n_w[15:0];
        v_13_next = 34'(n_12_reg) * (34'(rmax_reg) - 34'(rmin_reg))
                  + ((34'(rmax_reg) + 34'(rmin_reg)) <<< 15) + 34'sd32768;
        sc_w = v_13_reg[33:16];
        if (sc_w > 18'sd32767)
            noise_scaled = 16'sh7fff;
        else if (sc_w < -18'sd32768)
            noise_scaled = 16'sh8000;
        else
            noise_scaled = sc_w[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rmin_reg <= -16'sd32768;
            rmax_reg <= 16'sd32767;
        end
        else
        begin
            vld_reg <= {vld_reg[NV-2:0], start};
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RANGE_MIN: rmin_reg <= cfg_data;
                    CFG_RANGE_MAX: rmax_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xq_1_reg  <= 64'(coord_x) <<< (32 - COORD_FRAC_BITS);
        yq_1_reg  <= 64'(coord_y) <<< (32 - COORD_FRAC_BITS);
        skw_1_reg <= sum_x;
        xq_2_reg  <= xq_1_reg;
        yq_2_reg  <= yq_1_reg;
        i_2_reg   <= i_2_next[31:0];
        j_2_reg   <= j_2_next[31:0];
        x0_3_reg  <= x0_3_next[35:0];
        y0_3_reg  <= y0_3_next[35:0];
        ii_3_reg  <= pmod(34'(i_2_reg));
        jj_3_reg  <= pmod(34'(j_2_reg));
        x0_4_reg  <= x0_3_reg;
        y0_4_reg  <= y0_3_reg;
        i1_4_reg  <= x0_3_reg > y0_3_reg;
        x1_4_reg  <= x0_3_reg - ((x0_3_reg > y0_3_reg) ? 36'(ONE_Q32) : 36'sd0)
                   + 36'(G2_Q32);
        y1_4_reg  <= y0_3_reg - ((x0_3_reg > y0_3_reg) ? 36'sd0 : 36'(ONE_Q32))
                   + 36'(G2_Q32);
        x2_4_reg  <= x0_3_reg - 36'(ONE_Q32) + 36'(G2_Q32) + 36'(G2_Q32);
        y2_4_reg  <= y0_3_reg - 36'(ONE_Q32) + 36'(G2_Q32) + 36'(G2_Q32);
        ii_4_reg  <= ii_3_reg;
        pj0_4_reg <= pat((PW+1)'(jj_3_reg));
        pj1_4_reg <= pat((PW+1)'(jj_3_reg) + (PW+1)'(x0_3_reg <= y0_3_reg));
        pj2_4_reg <= pat((PW+1)'(jj_3_reg) + (PW+1)'(1));
        x0_5_reg  <= x0_4_reg;
        y0_5_reg  <= y0_4_reg;
        x1_5_reg  <= x1_4_reg;
        y1_5_reg  <= y1_4_reg;
        x2_5_reg  <= x2_4_reg;
        y2_5_reg  <= y2_4_reg;
        g0_5_reg  <= gsel(pat((PW+1)'(pmod(34'(ii_4_reg) + 34'(pj0_4_reg)))));
        g1_5_reg  <= gsel(pat((PW+1)'(pmod(34'(ii_4_reg) + 34'(i1_4_reg)
                                           + 34'(pj1_4_reg)))));
        g2_5_reg  <= gsel(pat((PW+1)'(pmod(34'(ii_4_reg) + 34'sd1 + 34'(pj2_4_reg)))));
        n_12_reg  <= n_12_next;
        v_13_reg  <= v_13_next;
    end

    sn2d_corner u_c0 (.clk(clk), .dx32(x0_5_reg), .dy32(y0_5_reg), .grad_sel(g0_5_reg),
                      .contrib(c0));
    sn2d_corner u_c1 (.clk(clk), .dx32(x1_5_reg), .dy32(y1_5_reg), .grad_sel(g1_5_reg),
                      .contrib(c1));
    sn2d_corner u_c2 (.clk(clk), .dx32(x2_5_reg), .dy32(y2_5_reg), .grad_sel(g2_5_reg),
                      .contrib(c2));

    logic signed [15:0] raw_13_reg;
    always_ff @(posedge clk)
    begin
        raw_13_reg <= n_12_reg;
    end

    assign noise_raw = raw_13_reg;
    assign done      = vld_reg[NV-1];
endmodule

[rtl/sn2d_checker.sv]
// ----------------------------------------------------------------------------
// sn2d_checker
// Port-level checks for the simplex noise pipeline.
// ----------------------------------------------------------------------------
module sn2d_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##13 done)
        else $error("missing result beat");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##13 !done)
        else $error("unrequested result beat");
endmodule

bind simplex_noise_2d sn2d_checker u_chk (.clk(clk), .rst_n(rst_n), .start(start),
    .busy(busy), .done(done));

[verif/simplex_noise_2d_tb.sv]
// ----------------------------------------------------------------------------
// simplex_noise_2d_tb
// Drives sample points into the 2d simplex noise block and checks the raw and
// range-scaled outputs against an in-bench fixed-point noise predictor.
// ----------------------------------------------------------------------------
module simplex_noise_2d_tb;
    import sn2d_pkg::*;

    localparam int CELL_MOD  = 256;
    localparam int GRAD_MOD  = 12;
    localparam int FRAC      = 16;
    localparam int LATENCY   = 13;
    localparam int WD_LIMIT  = 2000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        int                 gap;
    } point_t;

    typedef struct {
        sample_t raw;
        sample_t scaled;
    } noise_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic cfg_we;
    logic cfg_index;
    logic [15:0] cfg_data;
    logic done;
    logic signed [15:0] noise_raw;
    logic signed [15:0] noise_scaled;

    point_t pending_pts[$];
    noise_t expected_noise[$];
    int     lo_bound;
    int     hi_bound;
    int     errors;
    int     beats_in;
    int     beats_out;
    int     idle_cycles;
    int     gap_left;
    bit     stim_done;

    simplex_noise_2d dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coord_x(coord_x), .coord_y(coord_y),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .noise_raw(noise_raw), .noise_scaled(noise_scaled)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // floor shift for signed 64-bit
    function automatic longint fshr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint perm_of(input longint k);
        longint r;
        r = k % CELL_MOD;
        if (r < 0)
            r += CELL_MOD;
        return longint'(perm_table_at(r[7:0]));
    endfunction

    function automatic logic [7:0] perm_table_at(input logic [7:0] k);
        logic [7:0] p [0:255];
        p = '{
        151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,
        8,99,37,240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,
        35,11,32,57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,
        134,139,48,27,166,77,146,158,231,83,111,229,122,60,211,133,230,220,105,92,41,
        55,46,245,40,244,102,143,54,65,25,63,161,1,216,80,73,209,76,132,187,208,89,
        18,169,200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,52,217,226,
        250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,59,227,47,16,58,17,182,
        189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,101,155,167,43,
        172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,246,97,
        228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,
        107,49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,
        138,236,205,93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180};
        return p[k];
    endfunction

    function automatic longint corner_term(input longint dx32, input longint dy32,
                                           input longint h);
        logic signed [7:0] gx [0:15];
        logic signed [7:0] gy [0:15];
        longint dx, dy, t, t2, t4, dot;
        int g;
        gx = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0, 1, -1, 0, 0};
        gy = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1, 1, 1, -1, -1};
        dx = fshr(dx32, 8);
        dy = fshr(dy32, 8);
        t = 64'sh0000_8000_0000_0000 - dx * dx - dy * dy;
        g = int'((h % GRAD_MOD) & 15);
        if (t < 0)
            return 0;
        t = t >>> 18;
        t2 = (t * t) >>> 30;
        t4 = (t2 * t2) >>> 30;
        dot = longint'(gx[g]) * dx + longint'(gy[g]) * dy;
        return t4 * dot;
    endfunction

    function automatic noise_t predict_noise(input logic signed [31:0] px,
                                             input logic signed [31:0] py);
        longint xr, yr, bx, by, s, i, j, t, x0, y0, i1, j1, x1, y1, x2, y2;
        longint ii, jj, sum, n, v, sc, one, g2;
        noise_t r;
        one = 64'sd4294967296;
        g2 = 64'sd907633386;
        xr = longint'(px);
        yr = longint'(py);
        bx = xr * (64'sd1 << (32 - FRAC));
        by = yr * (64'sd1 << (32 - FRAC));
        s = fshr((xr + yr) * 64'sd393016785, FRAC - 2);
        i = fshr(bx + s, 32);
        j = fshr(by + s, 32);
        t = (i + j) * g2;
        x0 = bx - i * one + t;
        y0 = by - j * one + t;
        i1 = (x0 > y0) ? 1 : 0;
        j1 = 1 - i1;
        x1 = x0 - i1 * one + g2;
        y1 = y0 - j1 * one + g2;
        x2 = x0 - one + 2 * g2;
        y2 = y0 - one + 2 * g2;
        ii = i % CELL_MOD;
        jj = j % CELL_MOD;
        if (ii < 0) ii += CELL_MOD;
        if (jj < 0) jj += CELL_MOD;
        sum = corner_term(x0, y0, perm_of(ii + perm_of(jj)));
        sum += corner_term(x1, y1, perm_of(ii + i1 + perm_of(jj + j1)));
        sum += corner_term(x2, y2, perm_of(ii + 1 + perm_of(jj + 1)));
        n = fshr(sum * 70 + (64'sd1 <<< 38), 39);
        if (n > 32767) n = 32767;
        if (n < -32768) n = -32768;
        v = n * (longint'(hi_bound) - lo_bound) + (longint'(hi_bound) + lo_bound) * 32768;
        sc = fshr(v + 32768, 16);
        if (sc > 32767) sc = 32767;
        if (sc < -32768) sc = -32768;
        r.raw = n[15:0];
        r.scaled = sc[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at beat %0d: got %0d want %0d", what, beats_out, got, want);
        errors++;
    endtask

    // driver: one beat per queued point, after the idle gap queued with it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_noise.push_back(predict_noise(coord_x, coord_y));
                beats_in++;
            end
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_pts.size() > 0)
            begin
                point_t p;
                p = pending_pts.pop_front();
                if (p.gap > 0)
                begin
                    start <= 1'b0;
                    gap_left <= p.gap - 1;
                    pending_pts.push_front('{p.x, p.y, 0});
                end
                else
                begin
                    start <= 1'b1;
                    coord_x <= p.x;
                    coord_y <= p.y;
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            noise_t e;
            if (expected_noise.size() == 0)
            begin
                $display("unexpected result beat, raw %0d", noise_raw);
                errors++;
            end
            else
            begin
                e = expected_noise.pop_front();
                if (noise_raw !== e.raw)
                    report_mismatch("noise_raw", noise_raw, e.raw);
                if (noise_scaled !== e.scaled)
                    report_mismatch("noise_scaled", noise_scaled, e.scaled);
            end
            beats_out++;
        end
    end

    // watchdog on cycles without an accepted beat, a result or a cfg write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we || !rst_n || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic add_point(input logic signed [31:0] px, input logic signed [31:0] py,
                             input int gap);
        point_t p;
        p.x = px;
        p.y = py;
        p.gap = gap;
        pending_pts.push_back(p);
    endtask

    task automatic wait_drained();
        while (pending_pts.size() > 0 || start || gap_left > 0 || expected_noise.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_range(input logic idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        @(posedge clk);
        if (idx == CFG_RANGE_MIN)
            lo_bound = int'(sample_t'(val[15:0]));
        else
            hi_bound = int'(sample_t'(val[15:0]));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int k, mode, gap;
        logic signed [31:0] px, py;
        for (k = 0; k < count; k++)
        begin
            mode = $urandom_range(0, 9);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            px = $urandom;
            py = $urandom;
            if (mode < 5)
            begin
                // typical height-map span, up to 128 cells around the origin
                px = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
                py = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            end
            else if (mode == 5)
            begin
                // integer lattice points and the x0 == y0 diagonal
                px = {px[31:16], 16'h0000};
                py = ($urandom_range(0, 1)) ? px : {py[31:16], 16'h0000};
            end
            add_point(px, py, ($urandom_range(0, 4) == 0) ? 0 : gap);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        coord_x = '0;
        coord_y = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_RANGE_MIN;
        cfg_data = '0;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        lo_bound = -32768;
        hi_bound = 32767;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, integers, negative cells, diagonal
        add_point(32'sh0000_0000, 32'sh0000_0000, 0);
        add_point(32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        add_point(32'sh8000_0000, 32'sh8000_0000, 1);
        add_point(32'sh7fff_ffff, 32'sh8000_0000, 0);
        add_point(32'sh8000_0000, 32'sh7fff_ffff, 0);
        add_point(32'sh0001_0000, 32'sh0002_0000, 0);
        add_point(32'shffff_0000, 32'shfffe_0000, 2);
        add_point(32'shffff_ffff, 32'shffff_ffff, 0);
        add_point(32'sh0000_8000, 32'sh0000_8000, 0);
        add_point(32'sh0000_4000, 32'sh0000_c000, 0);
        add_point(32'sh0000_c000, 32'sh0000_4000, 0);
        add_point(32'shfff0_1234, 32'sh000f_abcd, 3);
        add_point(32'sh5555_5555, 32'shaaaa_aaaa, 0);
        add_point(32'shaaaa_aaaa, 32'sh5555_5555, 0);
        add_point(32'sh0100_0000, 32'shff00_0000, 0);
        add_point(32'sh0000_3a00, 32'sh0000_1200, 0);
        wait_drained();

        // sweep the scaled range: defaults, 0..255, inverted, zero-width, random
        random_phase(250);
        wait_drained();
        write_range(CFG_RANGE_MIN, 0);
        write_range(CFG_RANGE_MAX, 255);
        random_phase(250);
        wait_drained();
        write_range(CFG_RANGE_MIN, 32767);
        write_range(CFG_RANGE_MAX, -32768);
        random_phase(250);
        wait_drained();
        write_range(CFG_RANGE_MIN, -32768);
        write_range(CFG_RANGE_MAX, -32768);
        random_phase(150);
        wait_drained();
        write_range(CFG_RANGE_MIN, $urandom_range(0, 65535));
        write_range(CFG_RANGE_MAX, $urandom_range(0, 65535));
        random_phase(250);
        wait_drained();
        stim_done = 1'b1;

        $display("points sent %0d, results checked %0d, five range settings",
                 beats_in, beats_out);
        if (errors == 0 && expected_noise.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
